### hw/rtl/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// shared constants and types for the tile rasterizer core
// ----------------------------------------------------------------------------
package trr_pkg;

    localparam int TILE_DIM_DEF   = 16;
    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    // shared multiplier and accumulator widths
    localparam int MUL_W  = 18;
    localparam int PROD_W = 36;
    localparam int ACC_W  = 52;
    localparam int QUO_W  = 16;

    localparam int COLOR_W = 24;
    localparam int DEPTH_W = 16;
    localparam int FB_W    = COLOR_W + DEPTH_W;

    localparam logic [DEPTH_W-1:0] DEPTH_FAR = 16'hFFFF;

    localparam logic [1:0] REQ_VERTEX = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] SLOT_LAST  = 2'd2;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef logic signed [MUL_W-1:0]  t_mul_opnd;
    typedef logic signed [PROD_W-1:0] t_mul_prod;

endpackage

### hw/rtl/trr_mul.sv
// ----------------------------------------------------------------------------
// trr_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module trr_mul (
    input  logic               i_clk,
    input  trr_pkg::t_mul_opnd i_a,
    input  trr_pkg::t_mul_opnd i_b,
    output trr_pkg::t_mul_prod o_prod
);
    import trr_pkg::*;

    t_mul_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/trr_div.sv
// ----------------------------------------------------------------------------
// trr_div
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
module trr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [trr_pkg::ACC_W-1:0]   i_num,
    input  logic [trr_pkg::ACC_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [trr_pkg::QUO_W-1:0]   o_quo
);
    import trr_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= i_den << (QUO_W - 1);
            r_quo  <= '0;
            r_cnt  <= CNT_W'(QUO_W);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/trr_fb.sv
// ----------------------------------------------------------------------------
// trr_fb
// frame store holding color and depth per pixel, registered read
// ----------------------------------------------------------------------------
module trr_fb #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [trr_pkg::FB_W-1:0] i_wr_data,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [trr_pkg::FB_W-1:0] o_rd_data
);
    import trr_pkg::*;

    logic [FB_W-1:0] r_mem [DEPTH];
    logic [FB_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/triangle_tile_rasterizer_core.sv
// ----------------------------------------------------------------------------
// triangle_tile_rasterizer_core
// edge-function triangle rasterizer over one tile with a depth-tested store
// ----------------------------------------------------------------------------
// Input beats carry a request: a vertex for corner slot 0..2, a pixel read,
// or a clear of both stores to a fill color. The slot 2 vertex rasterizes the
// triangle over the named tile, clipped to the frame. Every input beat gives
// exactly one output beat. Frame width and height are written on the config
// channel, which is always ready; the user must write them only while the
// core is idle, which the core itself does not enforce. The sequencer steps
// one shared 18x18 multiplier and one restoring divider. A triangle runs a
// setup, then per tile pixel its edge functions and the store index; a
// covered pixel also takes its depth and, if that passes the depth test,
// three colors, each a six-product sum and a division. A clear writes all
// MAX_WIDTH*MAX_HEIGHT store entries, one store entry per cycle.
// Reset runs the same pass to set color zero and depth farthest; o_in_stall
// stays high meanwhile. A stall on the output holds the result in the output
// register; the next input beat is still taken and its result waits inside
// until the register frees up.
// ----------------------------------------------------------------------------
module triangle_tile_rasterizer_core #(
    parameter int TILE_DIM   = trr_pkg::TILE_DIM_DEF,
    parameter int MAX_WIDTH  = trr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = trr_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [1:0]                  i_vertex_slot,
    input  logic signed [15:0]          i_pos_x,
    input  logic signed [15:0]          i_pos_y,
    input  logic [15:0]                 i_vertex_depth,
    input  logic [23:0]                 i_rgb_value,
    input  logic [2:0]                  i_tile_col,
    input  logic [2:0]                  i_tile_row,
    input  logic [13:0]                 i_pixel_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [23:0]                 o_pixel_color,
    output logic [15:0]                 o_pixel_depth,
    output logic [8:0]                  o_pixels_written,
    output logic                        o_degenerate,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [7:0]                  i_cfg_data
);
    import trr_pkg::*;

    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(8 * TILE_DIM + MAX_WIDTH + MAX_HEIGHT + 1);

    localparam logic [3:0] S_SWEEP    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_EMIT     = 4'd3;
    localparam logic [3:0] S_AREA_M   = 4'd4;
    localparam logic [3:0] S_AREA_A   = 4'd5;
    localparam logic [3:0] S_AREA_CHK = 4'd6;
    localparam logic [3:0] S_PIX_M    = 4'd7;
    localparam logic [3:0] S_PIX_A    = 4'd8;
    localparam logic [3:0] S_COVER    = 4'd9;
    localparam logic [3:0] S_CH_M     = 4'd10;
    localparam logic [3:0] S_CH_A     = 4'd11;
    localparam logic [3:0] S_DIV_GO   = 4'd12;
    localparam logic [3:0] S_DIV      = 4'd13;
    localparam logic [3:0] S_WRITE    = 4'd14;
    localparam logic [3:0] S_NEXT     = 4'd15;

    localparam logic [2:0] OP_IDX = 3'd6;
    localparam logic [2:0] K_LAST = 3'd5;

    logic [3:0]               r_state;
    logic [7:0]               r_fw;
    logic [7:0]               r_fh;
    logic signed [15:0]       r_x [3];
    logic signed [15:0]       r_y [3];
    logic [DEPTH_W-1:0]       r_z [3];
    logic [COLOR_W-1:0]       r_c [3];
    logic [COLOR_W-1:0]       r_fill;
    logic [AW-1:0]            r_clr_addr;
    logic                     r_clr_req;
    logic [CW-1:0]            r_xs;
    logic [CW-1:0]            r_xe;
    logic [CW-1:0]            r_ys;
    logic [CW-1:0]            r_ye;
    logic [CW-1:0]            r_px;
    logic [CW-1:0]            r_py;
    logic                     r_swap;
    logic [ACC_W-1:0]         r_area;
    logic signed [ACC_W-1:0]  r_acc;
    logic [2:0]               r_op;
    logic [2:0]               r_k;
    logic [1:0]               r_ch;
    logic signed [PROD_W-1:0] r_w [3];
    logic [AW-1:0]            r_idx;
    logic [DEPTH_W-1:0]       r_znew;
    logic [COLOR_W-1:0]       r_col;
    logic [8:0]               r_cnt;
    logic                     r_rd_ok;
    logic [COLOR_W-1:0]       r_res_color;
    logic [DEPTH_W-1:0]       r_res_depth;
    logic [8:0]               r_res_cnt;
    logic                     r_res_degen;
    logic                     r_out_valid;
    logic [COLOR_W-1:0]       r_out_color;
    logic [DEPTH_W-1:0]       r_out_depth;
    logic [8:0]               r_out_cnt;
    logic                     r_out_degen;

    t_mul_opnd                mul_a;
    t_mul_opnd                mul_b;
    t_mul_prod                mul_prod;
    logic signed [ACC_W-1:0]  p_ext;
    logic signed [ACC_W-1:0]  acc_sub;
    logic                     div_start;
    logic                     div_busy;
    logic [QUO_W-1:0]         div_quo;
    logic                     fb_we;
    logic [AW-1:0]            fb_waddr;
    logic [FB_W-1:0]          fb_wdata;
    logic [AW-1:0]            fb_raddr;
    logic [FB_W-1:0]          fb_rdata;
    logic [31:0]              rd_addr32;
    logic [31:0]              idx32;
    logic                     in_acc;
    logic [CW-1:0]            width_eff;
    logic [CW-1:0]            height_eff;
    logic [CW-1:0]            t_xs;
    logic [CW-1:0]            t_ys;
    logic [CW-1:0]            t_xe;
    logic [CW-1:0]            t_ye;
    logic [CW-1:0]            t_xs_end;
    logic [CW-1:0]            t_ys_end;

    function automatic logic [1:0] f_ord(input logic [1:0] i, input logic sw);
        logic [1:0] o;
        case (i)
            2'd0:    o = 2'd0;
            2'd1:    o = sw ? 2'd2 : 2'd1;
            default: o = sw ? 2'd1 : 2'd2;
        endcase
        return o;
    endfunction

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // tile bounds clipped to the active frame
    always_comb begin
        width_eff  = (CW'(r_fw) < CW'(MAX_WIDTH)) ? CW'(r_fw) : CW'(MAX_WIDTH);
        height_eff = (CW'(r_fh) < CW'(MAX_HEIGHT)) ? CW'(r_fh) : CW'(MAX_HEIGHT);
        t_xs       = CW'(CW'(i_tile_col) * TILE_DIM);
        t_ys       = CW'(CW'(i_tile_row) * TILE_DIM);
        t_xs_end   = CW'(t_xs + CW'(TILE_DIM));
        t_ys_end   = CW'(t_ys + CW'(TILE_DIM));
        t_xe       = (t_xs_end < width_eff) ? t_xs_end : width_eff;
        t_ye       = (t_ys_end < height_eff) ? t_ys_end : height_eff;
    end

    // operand select for the shared multiplier
    always_comb begin
        logic [1:0]     e_pair;
        logic [1:0]     c_p;
        logic [1:0]     c_q;
        logic [1:0]     w_i;
        logic [1:0]     c_w;
        t_mul_opnd      xp;
        t_mul_opnd      yp;
        t_mul_opnd      xq;
        t_mul_opnd      yq;
        t_mul_opnd      cx;
        t_mul_opnd      cy;
        logic [15:0]    val;
        logic [PROD_W-1:0] wv;
        e_pair = r_op[2:1];
        case (e_pair)
            2'd0: begin
                c_p = f_ord(2'd1, r_swap);
                c_q = f_ord(2'd2, r_swap);
            end
            2'd1: begin
                c_p = f_ord(2'd2, r_swap);
                c_q = f_ord(2'd0, r_swap);
            end
            default: begin
                c_p = f_ord(2'd0, r_swap);
                c_q = f_ord(2'd1, r_swap);
            end
        endcase
        xp  = MUL_W'(r_x[c_p]);
        yp  = MUL_W'(r_y[c_p]);
        xq  = MUL_W'(r_x[c_q]);
        yq  = MUL_W'(r_y[c_q]);
        cx  = t_mul_opnd'(MUL_W'({r_px, 4'b1000}));
        cy  = t_mul_opnd'(MUL_W'({r_py, 4'b1000}));
        w_i = r_k[2:1];
        c_w = f_ord(w_i, r_swap);
        wv  = r_w[w_i];
        case (r_ch)
            2'd0:    val = r_z[c_w];
            2'd1:    val = {8'd0, r_c[c_w][23:16]};
            2'd2:    val = {8'd0, r_c[c_w][15:8]};
            default: val = {8'd0, r_c[c_w][7:0]};
        endcase
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_AREA_M: begin
                if (r_op[0] == 1'b0) begin
                    mul_a = MUL_W'(r_x[2]) - MUL_W'(r_x[0]);
                    mul_b = MUL_W'(r_y[1]) - MUL_W'(r_y[0]);
                end else begin
                    mul_a = MUL_W'(r_y[2]) - MUL_W'(r_y[0]);
                    mul_b = MUL_W'(r_x[1]) - MUL_W'(r_x[0]);
                end
            end
            S_PIX_M: begin
                if (r_op == OP_IDX) begin
                    mul_a = t_mul_opnd'(MUL_W'(r_py));
                    mul_b = t_mul_opnd'(MUL_W'(width_eff));
                end else if (r_op[0] == 1'b0) begin
                    mul_a = cx - xp;
                    mul_b = yq - yp;
                end else begin
                    mul_a = cy - yp;
                    mul_b = xq - xp;
                end
            end
            S_CH_M: begin
                // weight split into low and high 17-bit halves
                mul_a = r_k[0] ? t_mul_opnd'({1'b0, wv[33:17]})
                               : t_mul_opnd'({1'b0, wv[16:0]});
                mul_b = t_mul_opnd'(MUL_W'(val));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_ext   = ACC_W'(mul_prod);
    assign acc_sub = r_acc - p_ext;
    assign idx32   = 32'(unsigned'(mul_prod)) + 32'(r_px);

    assign div_start = (r_state == S_DIV_GO);

    assign rd_addr32 = 32'(i_pixel_addr);
    assign fb_raddr  = (r_state == S_IDLE) ? rd_addr32[AW-1:0] : r_idx;
    assign fb_we     = (r_state == S_SWEEP) || (r_state == S_WRITE);
    assign fb_waddr  = (r_state == S_SWEEP) ? r_clr_addr : r_idx;
    assign fb_wdata  = (r_state == S_SWEEP) ? {r_fill, DEPTH_FAR} : {r_col, r_znew};

    trr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    trr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (unsigned'(r_acc)),
        .i_den   (r_area),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    trr_fb #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_fb (
        .i_clk     (i_clk),
        .i_wr_en   (fb_we),
        .i_wr_addr (fb_waddr),
        .i_wr_data (fb_wdata),
        .i_rd_addr (fb_raddr),
        .o_rd_data (fb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_fw        <= 8'd128;
            r_fh        <= 8'd128;
            r_fill      <= '0;
            r_clr_addr  <= '0;
            r_clr_req   <= 1'b0;
            r_out_valid <= 1'b0;
            r_op        <= '0;
            r_k         <= '0;
            r_ch        <= '0;
            for (int i = 0; i < 3; i++) begin
                r_x[i] <= '0;
                r_y[i] <= '0;
                r_z[i] <= '0;
                r_c[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    r_fw <= i_cfg_data;
                end else if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    r_fh <= i_cfg_data;
                end
            end
            // the emit state reloads the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (32'(r_clr_addr) == 32'(STORE - 1)) begin
                        r_state <= r_clr_req ? S_EMIT : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_color <= '0;
                        r_res_depth <= '0;
                        r_res_cnt   <= '0;
                        r_res_degen <= 1'b0;
                        case (i_req_type)
                            REQ_VERTEX: begin
                                if (i_vertex_slot <= SLOT_LAST) begin
                                    r_x[i_vertex_slot] <= i_pos_x;
                                    r_y[i_vertex_slot] <= i_pos_y;
                                    r_z[i_vertex_slot] <= i_vertex_depth;
                                    r_c[i_vertex_slot] <= i_rgb_value;
                                end
                                if (i_vertex_slot == SLOT_LAST) begin
                                    r_xs    <= t_xs;
                                    r_ys    <= t_ys;
                                    r_xe    <= t_xe;
                                    r_ye    <= t_ye;
                                    r_op    <= '0;
                                    r_state <= S_AREA_M;
                                end else begin
                                    r_state <= S_EMIT;
                                end
                            end
                            REQ_READ: begin
                                r_rd_ok <= (rd_addr32 < 32'(STORE));
                                r_state <= S_READ;
                            end
                            REQ_CLEAR: begin
                                r_fill     <= i_rgb_value;
                                r_clr_addr <= '0;
                                r_clr_req  <= 1'b1;
                                r_state    <= S_SWEEP;
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (r_rd_ok) begin
                        r_res_color <= fb_rdata[FB_W-1:DEPTH_W];
                        r_res_depth <= fb_rdata[DEPTH_W-1:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_color <= r_res_color;
                        r_out_depth <= r_res_depth;
                        r_out_cnt   <= r_res_cnt;
                        r_out_degen <= r_res_degen;
                        r_state     <= S_IDLE;
                    end
                end
                S_AREA_M: begin
                    r_state <= S_AREA_A;
                end
                S_AREA_A: begin
                    if (r_op[0] == 1'b0) begin
                        r_acc   <= p_ext;
                        r_op    <= r_op + 1'b1;
                        r_state <= S_AREA_M;
                    end else begin
                        r_acc   <= acc_sub;
                        r_state <= S_AREA_CHK;
                    end
                end
                S_AREA_CHK: begin
                    r_swap <= r_acc[ACC_W-1];
                    r_area <= r_acc[ACC_W-1] ? unsigned'(-r_acc) : unsigned'(r_acc);
                    r_px   <= r_xs;
                    r_py   <= r_ys;
                    r_op   <= '0;
                    r_cnt  <= '0;
                    if (r_acc == '0) begin
                        r_res_degen <= 1'b1;
                        r_state     <= S_EMIT;
                    end else if (r_xs >= r_xe || r_ys >= r_ye) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_PIX_M;
                    end
                end
                S_PIX_M: begin
                    r_state <= S_PIX_A;
                end
                S_PIX_A: begin
                    if (r_op == OP_IDX) begin
                        r_idx   <= idx32[AW-1:0];
                        r_state <= S_COVER;
                    end else begin
                        if (r_op[0] == 1'b0) begin
                            r_acc <= p_ext;
                        end else begin
                            r_w[r_op[2:1]] <= acc_sub[PROD_W-1:0];
                        end
                        r_op    <= r_op + 1'b1;
                        r_state <= S_PIX_M;
                    end
                end
                S_COVER: begin
                    r_ch <= '0;
                    r_k  <= '0;
                    if (r_w[0][PROD_W-1] || r_w[1][PROD_W-1] || r_w[2][PROD_W-1]) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_CH_M;
                    end
                end
                S_CH_M: begin
                    r_state <= S_CH_A;
                end
                S_CH_A: begin
                    if (r_k == '0) begin
                        r_acc <= p_ext;
                    end else if (r_k[0]) begin
                        r_acc <= r_acc + (p_ext <<< 17);
                    end else begin
                        r_acc <= r_acc + p_ext;
                    end
                    if (r_k == K_LAST) begin
                        r_state <= S_DIV_GO;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CH_M;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_k <= '0;
                        case (r_ch)
                            2'd0: begin
                                if (div_quo >= fb_rdata[DEPTH_W-1:0]) begin
                                    r_state <= S_NEXT;
                                end else begin
                                    r_znew  <= div_quo;
                                    r_ch    <= 2'd1;
                                    r_state <= S_CH_M;
                                end
                            end
                            2'd1: begin
                                r_col[23:16] <= (div_quo > 16'd255) ? 8'hFF : div_quo[7:0];
                                r_ch         <= 2'd2;
                                r_state      <= S_CH_M;
                            end
                            2'd2: begin
                                r_col[15:8] <= (div_quo > 16'd255) ? 8'hFF : div_quo[7:0];
                                r_ch        <= 2'd3;
                                r_state     <= S_CH_M;
                            end
                            default: begin
                                r_col[7:0] <= (div_quo > 16'd255) ? 8'hFF : div_quo[7:0];
                                r_state    <= S_WRITE;
                            end
                        endcase
                    end
                end
                S_WRITE: begin
                    if (r_cnt != 9'h1FF) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_op <= '0;
                    if (CW'(r_px + 1'b1) < r_xe) begin
                        r_px    <= r_px + 1'b1;
                        r_state <= S_PIX_M;
                    end else if (CW'(r_py + 1'b1) < r_ye) begin
                        r_px    <= r_xs;
                        r_py    <= r_py + 1'b1;
                        r_state <= S_PIX_M;
                    end else begin
                        r_res_cnt <= r_cnt;
                        r_state   <= S_EMIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_color    = r_out_color;
    assign o_pixel_depth    = r_out_depth;
    assign o_pixels_written = r_out_cnt;
    assign o_degenerate     = r_out_degen;

endmodule

### test/triangle_tile_rasterizer_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tile_rasterizer_core_checker
// watches the request, result and config channels of the rasterizer core,
// keeps its own frame store and corner registers, and compares every result
// beat field by field with the oldest predicted pixel result
// ----------------------------------------------------------------------------
module triangle_tile_rasterizer_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_vertex_slot,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_vertex_depth,
    input  logic [23:0] i_rgb_value,
    input  logic [2:0]  i_tile_col,
    input  logic [2:0]  i_tile_row,
    input  logic [13:0] i_pixel_addr,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [23:0] i_pixel_color,
    input  logic [15:0] i_pixel_depth,
    input  logic [8:0]  i_pixels_written,
    input  logic        i_degenerate,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_triangles,
    output int          o_drawn
);
    import trr_pkg::*;

    localparam int STORE_N = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [DEPTH_W-1:0] depth;
        logic [8:0]         written;
        logic               degen;
    } t_pixel_result;

    t_pixel_result      expected_q[$];
    logic [COLOR_W-1:0] color_mem [STORE_N];
    logic [DEPTH_W-1:0] depth_mem [STORE_N];
    logic [15:0]        corner_x [3];
    logic [15:0]        corner_y [3];
    logic [15:0]        corner_z [3];
    logic [23:0]        corner_rgb [3];
    logic [7:0]         frame_w;
    logic [7:0]         frame_h;

    initial begin
        o_errors = 0;
        o_results = 0;
        o_triangles = 0;
        o_drawn = 0;
        frame_w = 8'd128;
        frame_h = 8'd128;
        for (int k = 0; k < 3; k++) begin
            corner_x[k] = '0;
            corner_y[k] = '0;
            corner_z[k] = '0;
            corner_rgb[k] = '0;
        end
        for (int k = 0; k < STORE_N; k++) begin
            color_mem[k] = '0;
            depth_mem[k] = DEPTH_FAR;
        end
    end

    assign o_pending = expected_q.size();

    task automatic report(input string what, input longint want, input longint got);
        o_errors++;
        $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    function automatic longint edge_val(input longint ax, ay, bx, by, px, py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function automatic logic [7:0] blend(input longint w0, w1, w2,
                                         input logic [7:0] ca, cb, cc,
                                         input longint area);
        longint q;
        q = (w0 * ca + w1 * cb + w2 * cc) / area;
        return q > 255 ? 8'hFF : q[7:0];
    endfunction

    // walks the clipped tile and updates the local store like the core should
    function automatic t_pixel_result draw_triangle(input logic [2:0] tc, tr);
        t_pixel_result res;
        longint x [3];
        longint y [3];
        longint area, w0, w1, w2, z, cxp, cyp;
        int ia, ib, ic, wd, ht, xs, ys, xe, ye, idx;
        res = '{default: '0};
        ia = 0; ib = 1; ic = 2;
        for (int k = 0; k < 3; k++) begin
            x[k] = longint'($signed(corner_x[k]));
            y[k] = longint'($signed(corner_y[k]));
        end
        area = edge_val(x[0], y[0], x[1], y[1], x[2], y[2]);
        if (area == 0) begin
            res.degen = 1'b1;
            return res;
        end
        if (area < 0) begin
            area = -area;
            ib = 2;
            ic = 1;
        end
        wd = frame_w < MAX_WIDTH_DEF ? frame_w : MAX_WIDTH_DEF;
        ht = frame_h < MAX_HEIGHT_DEF ? frame_h : MAX_HEIGHT_DEF;
        xs = tc * TILE_DIM_DEF;
        ys = tr * TILE_DIM_DEF;
        xe = xs + TILE_DIM_DEF < wd ? xs + TILE_DIM_DEF : wd;
        ye = ys + TILE_DIM_DEF < ht ? ys + TILE_DIM_DEF : ht;
        for (int py = ys; py < ye; py++) begin
            for (int px = xs; px < xe; px++) begin
                cxp = px * 16 + 8;
                cyp = py * 16 + 8;
                w0 = edge_val(x[ib], y[ib], x[ic], y[ic], cxp, cyp);
                w1 = edge_val(x[ic], y[ic], x[ia], y[ia], cxp, cyp);
                w2 = edge_val(x[ia], y[ia], x[ib], y[ib], cxp, cyp);
                if (w0 < 0 || w1 < 0 || w2 < 0)
                    continue;
                z = (w0 * corner_z[ia] + w1 * corner_z[ib] + w2 * corner_z[ic]) / area;
                if (z > 65535)
                    z = 65535;
                idx = py * wd + px;
                if (idx >= STORE_N || z >= depth_mem[idx])
                    continue;
                depth_mem[idx] = z[15:0];
                color_mem[idx] = {
                    blend(w0, w1, w2, corner_rgb[ia][23:16], corner_rgb[ib][23:16],
                          corner_rgb[ic][23:16], area),
                    blend(w0, w1, w2, corner_rgb[ia][15:8], corner_rgb[ib][15:8],
                          corner_rgb[ic][15:8], area),
                    blend(w0, w1, w2, corner_rgb[ia][7:0], corner_rgb[ib][7:0],
                          corner_rgb[ic][7:0], area)};
                if (res.written != 9'd511)
                    res.written++;
            end
        end
        return res;
    endfunction

    function automatic t_pixel_result apply_request();
        t_pixel_result res;
        res = '{default: '0};
        case (i_req_type)
            REQ_VERTEX: begin
                if (i_vertex_slot <= SLOT_LAST) begin
                    corner_x[i_vertex_slot] = i_pos_x;
                    corner_y[i_vertex_slot] = i_pos_y;
                    corner_z[i_vertex_slot] = i_vertex_depth;
                    corner_rgb[i_vertex_slot] = i_rgb_value;
                    if (i_vertex_slot == SLOT_LAST) begin
                        res = draw_triangle(i_tile_col, i_tile_row);
                        o_triangles++;
                        o_drawn += res.written;
                    end
                end
            end
            REQ_READ: begin
                if (i_pixel_addr < STORE_N) begin
                    res.color = color_mem[i_pixel_addr];
                    res.depth = depth_mem[i_pixel_addr];
                end
            end
            REQ_CLEAR: begin
                for (int k = 0; k < STORE_N; k++) begin
                    color_mem[k] = i_rgb_value;
                    depth_mem[k] = DEPTH_FAR;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pixel_result want;
        t_pixel_result fresh;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH)
                    frame_w = i_cfg_data;
                else
                    frame_h = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected result beat", 0, i_pixels_written);
                end else begin
                    want = expected_q.pop_front();
                    if (i_pixel_color !== want.color)
                        report("pixel_color", want.color, i_pixel_color);
                    if (i_pixel_depth !== want.depth)
                        report("pixel_depth", want.depth, i_pixel_depth);
                    if (i_pixels_written !== want.written)
                        report("pixels_written", want.written, i_pixels_written);
                    if (i_degenerate !== want.degen)
                        report("degenerate", want.degen, i_degenerate);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = apply_request();
                expected_q = {expected_q, fresh};
            end
        end
    end

endmodule

### test/triangle_tile_rasterizer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tile_rasterizer_core_test
// drives vertex, read, clear and odd requests into the rasterizer core under
// random valid gaps and output stalls, changes the frame size between phases,
// and reports the verdict of the checker
// ----------------------------------------------------------------------------
module triangle_tile_rasterizer_core_test;
    import trr_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam logic [1:0] REQ_BOGUS = 2'd3;
    localparam logic [1:0] SLOT_BOGUS = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_BOGUS;
    logic [1:0]  vertex_slot = '0;
    logic [15:0] pos_x = '0;
    logic [15:0] pos_y = '0;
    logic [15:0] vertex_depth = '0;
    logic [23:0] rgb_value = '0;
    logic [2:0]  tile_col = '0;
    logic [2:0]  tile_row = '0;
    logic [13:0] pixel_addr = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] pixel_color;
    logic [15:0] pixel_depth;
    logic [8:0]  pixels_written;
    logic        degenerate;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_FRAME_WIDTH;
    logic [7:0]  cfg_data = '0;
    int          errors, pending, results, triangles, drawn;
    int          sent = 0;
    int          cur_w = 128;
    int          cur_h = 128;
    bit          quiet = 1'b0;
    bit          hold_now = 1'b0;
    bit          held = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    triangle_tile_rasterizer_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_vertex_slot(vertex_slot),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vertex_depth(vertex_depth),
        .i_rgb_value(rgb_value), .i_tile_col(tile_col), .i_tile_row(tile_row),
        .i_pixel_addr(pixel_addr),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_pixel_color(pixel_color), .o_pixel_depth(pixel_depth),
        .o_pixels_written(pixels_written), .o_degenerate(degenerate),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    triangle_tile_rasterizer_core_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_req_type(req_type), .i_vertex_slot(vertex_slot),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vertex_depth(vertex_depth),
        .i_rgb_value(rgb_value), .i_tile_col(tile_col), .i_tile_row(tile_row),
        .i_pixel_addr(pixel_addr),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_pixel_color(pixel_color), .i_pixel_depth(pixel_depth),
        .i_pixels_written(pixels_written), .i_degenerate(degenerate),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_triangles(triangles), .o_drawn(drawn)
    );

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_now) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_now = 1'b0;
            end else begin
                out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 16);
            end
        end
    end

    initial begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic send(input logic [1:0] req, input logic [1:0] slot,
                        input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z, input logic [23:0] rgb,
                        input logic [2:0] tc, input logic [2:0] tr,
                        input logic [13:0] addr);
        while (!quiet && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        vertex_slot <= slot;
        pos_x <= x;
        pos_y <= y;
        vertex_depth <= z;
        rgb_value <= rgb;
        tile_col <= tc;
        tile_row <= tr;
        pixel_addr <= addr;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic vertex(input logic [1:0] slot, input logic [15:0] x, y, z,
                          input logic [23:0] rgb, input logic [2:0] tc, tr);
        send(REQ_VERTEX, slot, x, y, z, rgb, tc, tr, 14'($urandom));
    endtask

    task automatic read_pixel(input logic [13:0] addr);
        send(REQ_READ, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             24'($urandom), 3'($urandom), 3'($urandom), addr);
    endtask

    task automatic clear_stores(input logic [23:0] fill);
        send(REQ_CLEAR, 2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             fill, 3'($urandom), 3'($urandom), 14'($urandom));
    endtask

    // frame registers change only with the core drained
    task automatic set_frame(input int w, input int h);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || in_stall) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= 8'(w);
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data <= 8'(h);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // q.4 coordinate in and just around the active frame
    function automatic logic [15:0] near_coord(input int span);
        return 16'($urandom_range(span * 16 + 48) - 24);
    endfunction

    function automatic logic [13:0] frame_addr();
        int lim;
        lim = cur_w * cur_h;
        if (lim == 0 || $urandom_range(9) == 0)
            return 14'($urandom);
        return 14'($urandom_range(lim - 1));
    endfunction

    task automatic random_triangle();
        int sw, sh, tc, tr;
        sw = cur_w > 16 ? 16 : cur_w;
        sh = cur_h > 16 ? 16 : cur_h;
        tc = $urandom_range(4) == 0 ? $urandom_range(7) : 0;
        tr = $urandom_range(4) == 0 ? $urandom_range(7) : 0;
        for (int s = 0; s < 3; s++)
            vertex(s[1:0], near_coord(sw), near_coord(sh), 16'($urandom),
                   24'($urandom), 3'(tc), 3'(tr));
        repeat ($urandom_range(1, 2)) read_pixel(frame_addr());
    endtask

    initial begin
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the full frame
        set_frame(128, 128);
        // clockwise triangle in the far corner tile, extreme depth and color
        vertex(2'd0, 16'(120 * 16), 16'(120 * 16), 16'd0, 24'hFFFFFF, 3'd7, 3'd7);
        vertex(2'd1, 16'(120 * 16), 16'(126 * 16), 16'hFFFF, 24'h000000, 3'd7, 3'd7);
        vertex(2'd2, 16'(126 * 16), 16'(120 * 16), 16'h8000, 24'hFF00FF, 3'd7, 3'd7);
        read_pixel(14'(121 * 128 + 121));
        // same triangle again fails the strict depth test everywhere
        vertex(2'd2, 16'(126 * 16), 16'(120 * 16), 16'h8000, 24'hFF00FF, 3'd7, 3'd7);
        // collinear corners
        vertex(2'd0, 16'd0, 16'd0, 16'd5, 24'h123456, 3'd0, 3'd0);
        vertex(2'd1, 16'd32, 16'd32, 16'd5, 24'h123456, 3'd0, 3'd0);
        vertex(2'd2, 16'd64, 16'd64, 16'd5, 24'h123456, 3'd0, 3'd0);
        // huge triangle over tile zero from the coordinate extremes
        vertex(2'd0, 16'h8000, 16'h8000, 16'h0010, 24'hFFFFFF, 3'd0, 3'd0);
        vertex(2'd1, 16'h7FFF, 16'h8000, 16'h0200, 24'h00FF00, 3'd0, 3'd0);
        vertex(2'd2, 16'h8000, 16'h7FFF, 16'hFFFF, 24'h0000FF, 3'd0, 3'd0);
        read_pixel(14'd0);
        read_pixel(14'h3FFF);
        read_pixel(14'(15 * 128 + 15));
        vertex(SLOT_BOGUS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 3'd7, 3'd7);
        send(REQ_BOGUS, 2'd2, 16'hFFFF, 16'h0, 16'hFFFF, 24'hFFFFFF, 3'd7, 3'd7, 14'h3FFF);
        clear_stores(24'hA5A5A5);
        read_pixel(14'd77);
        set_frame(0, 0);
        vertex(2'd2, 16'd400, 16'd16, 16'd1, 24'h00FFFF, 3'd0, 3'd0);
        set_frame(255, 255);
        vertex(2'd2, 16'h8000, 16'h7FFF, 16'd1, 24'h0000FF, 3'd7, 3'd7);
        read_pixel(14'h3FFF);
        set_frame(1, 1);
        vertex(2'd2, 16'h8000, 16'h7FFF, 16'd0, 24'h0000FF, 3'd3, 3'd3);
        vertex(2'd2, 16'h8000, 16'h7FFF, 16'd0, 24'h0000FF, 3'd0, 3'd0);
        read_pixel(14'd0);

        // random part, small frames keep the walks short
        while (sent < ITEM_TARGET) begin
            if (sent % 150 < 5) begin
                set_frame($urandom_range(1, 10), $urandom_range(1, 10));
                if ($urandom_range(2) == 0)
                    clear_stores(24'($urandom));
            end
            quiet = sent > 500 && sent < 700;
            if (sent > 900 && !held) begin
                held = 1'b1;
                hold_now = 1'b1;
                repeat (12) read_pixel(frame_addr());
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                random_triangle();
            end else if (pick < 82) begin
                read_pixel(frame_addr());
            end else if (pick < 88) begin
                vertex(2'($urandom_range(1)), 16'($urandom), 16'($urandom),
                       16'($urandom), 24'($urandom), 3'($urandom), 3'($urandom));
            end else if (pick < 92) begin
                vertex(SLOT_LAST, 16'($urandom), 16'($urandom), 16'($urandom),
                       24'($urandom), 3'($urandom_range(1)), 3'($urandom_range(1)));
            end else if (pick < 96) begin
                vertex(SLOT_BOGUS, 16'($urandom), 16'($urandom), 16'($urandom),
                       24'($urandom), 3'($urandom), 3'($urandom));
            end else begin
                send(REQ_BOGUS, 2'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 24'($urandom), 3'($urandom), 3'($urandom),
                     14'($urandom));
            end
        end
        in_valid <= 1'b0;
        quiet = 1'b1;

        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("sent %0d requests, checked %0d results", sent, results);
        $display("%0d triangles rasterized, %0d pixels written", triangles, drawn);
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
